// ===== hdl/text_record_utf8_checker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text record checker
// Concurrent assertion wrappers that can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef TEXT_RECORD_UTF8_CHECKER_UNIT_DEFINES_SVH
`define TEXT_RECORD_UTF8_CHECKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TRU8_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text record checker assertion failed");

`define TRU8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text record checker assertion failed");

`else

`define TRU8_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define TRU8_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/tru8_pkg.sv =====
// ----------------------------------------------------------------------------
// Text record checker package
// Codes, widths, reset values and the UTF-8 decode step function.
// ----------------------------------------------------------------------------
package tru8_pkg;

    localparam int unsigned POS_W       = 17;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 17;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0]  NAME_LIMIT_RESET  = 8'd64;
    localparam logic [15:0] BODY_LIMIT_RESET  = 16'd4096;
    localparam logic [8:0]  NAME_BUF_RESET    = 9'd256;
    localparam logic [16:0] BODY_BUF_RESET    = 17'd65536;

    localparam logic [7:0] VERSION_BYTE = 8'h01;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NAME_LIMIT = 2'd0,
        REG_BODY_LIMIT = 2'd1,
        REG_NAME_BUF   = 2'd2,
        REG_BODY_BUF   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SEC_HEADER = 2'd0,
        SEC_NAME   = 2'd1,
        SEC_BODY   = 2'd2,
        SEC_BEYOND = 2'd3
    } section_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_SHORT     = 4'd1,
        ERR_VERSION   = 4'd2,
        ERR_NAME_LEN  = 4'd3,
        ERR_BODY_LEN  = 4'd4,
        ERR_MISMATCH  = 4'd5,
        ERR_CAPACITY  = 4'd6,
        ERR_NAME_TEXT = 4'd7,
        ERR_BODY_TEXT = 4'd8
    } err_t;

    typedef enum logic [2:0] {
        CLS_80_BF = 3'd0,
        CLS_A0_BF = 3'd1,
        CLS_80_9F = 3'd2,
        CLS_90_BF = 3'd3,
        CLS_80_8F = 3'd4
    } cls_t;

    typedef struct packed {
        logic       bad;
        logic [1:0] pend;
        cls_t       cls;
    } text_step_t;

    function automatic logic in_class(input logic [7:0] b, input cls_t cls);
        logic hit;
        case (cls)
            CLS_A0_BF: hit = (b >= 8'ha0) && (b <= 8'hbf);
            CLS_80_9F: hit = (b >= 8'h80) && (b <= 8'h9f);
            CLS_90_BF: hit = (b >= 8'h90) && (b <= 8'hbf);
            CLS_80_8F: hit = (b >= 8'h80) && (b <= 8'h8f);
            default:   hit = (b >= 8'h80) && (b <= 8'hbf);
        endcase
        return hit;
    endfunction

    // One byte of strict UTF-8 decoding; bad is set when the byte breaks the text.
    function automatic text_step_t text_step(input logic [1:0] pend, input cls_t cls,
                                             input logic [7:0] b, input logic body);
        text_step_t r;
        logic       layout;
        r.bad  = 1'b0;
        r.pend = pend;
        r.cls  = cls;
        layout = body && ((b == 8'h09) || (b == 8'h0a) || (b == 8'h0d));
        if (pend != 2'd0) begin
            r.cls = CLS_80_BF;
            if (!in_class(b, cls)) begin
                r.pend = 2'd0;
                r.bad  = 1'b1;
            end else begin
                r.pend = pend - 2'd1;
            end
        end else if (b < 8'h80) begin
            r.bad = ((b < 8'h20) && !layout) || (b == 8'h7f);
        end else if ((b >= 8'hc2) && (b <= 8'hdf)) begin
            r.pend = 2'd1;
            r.cls  = CLS_80_BF;
        end else if ((b >= 8'he0) && (b <= 8'hef)) begin
            r.pend = 2'd2;
            r.cls  = (b == 8'he0) ? CLS_A0_BF : (b == 8'hed) ? CLS_80_9F : CLS_80_BF;
        end else if ((b >= 8'hf0) && (b <= 8'hf4)) begin
            r.pend = 2'd3;
            r.cls  = (b == 8'hf0) ? CLS_90_BF : (b == 8'hf4) ? CLS_80_8F : CLS_80_BF;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== hdl/tru8_in_if.sv =====
// ----------------------------------------------------------------------------
// Record byte channel
// Valid/ready channel carrying one record byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface tru8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/tru8_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the echoed byte, its section and the verdict.
// ----------------------------------------------------------------------------
interface tru8_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  section;
    logic        done_res;
    logic        record_ok;
    logic [3:0]  error_code;
    logic [7:0]  name_bytes;
    logic [15:0] body_bytes;

    modport source (output valid, output out_byte, output section, output done_res,
                    output record_ok, output error_code, output name_bytes,
                    output body_bytes, input ready);
    modport sink   (input valid, input out_byte, input section, input done_res,
                    input record_ok, input error_code, input name_bytes,
                    input body_bytes, output ready);
endinterface

// ===== hdl/tru8_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tru8_cfg_if;
    import tru8_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== hdl/text_record_utf8_checker_unit.sv =====
// ----------------------------------------------------------------------------
// Text record UTF-8 checker
// Streams a stored record byte by byte, tags each byte with its section and
// gives the record verdict with the highest-priority error on the last byte.
// ----------------------------------------------------------------------------
//
//  Channel   Role   Carries
//  -------   ----   ---------------------------------------------------------
//  cfg       sink   reg_index, wr_data (limits and buffer sizes)
//  record    sink   data_byte, last_byte
//  verdict   source out_byte, section, done_res, record_ok, error_code,
//                   name_bytes, body_bytes
//
// Each item passes through the input register and then the result register,
// and one item is taken every cycle while the result side does not stall.
// The per-record state is updated as an item moves into the result register.
// A result stall holds the result and a full input register, dropping ready.
// Reset clears the record state and loads the default limits.
//
`include "text_record_utf8_checker_unit_defines.svh"

module text_record_utf8_checker_unit (
    input  logic      clk,
    input  logic      rst_n,
    tru8_cfg_if.sink  cfg,
    tru8_in_if.sink   record,
    tru8_out_if.source verdict
);
    import tru8_pkg::*;

    logic [7:0]       name_limit_reg;
    logic [15:0]      body_limit_reg;
    logic [8:0]       name_buf_reg;
    logic [16:0]      body_buf_reg;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       name_len_reg, name_len_next;
    logic [15:0]      body_len_reg, body_len_next;
    err_t             first_err_reg, first_err_next;
    logic [1:0]       pend_reg, pend_next;
    cls_t             cls_reg, cls_next;
    logic             name_bad_reg, name_bad_next;
    logic             body_bad_reg, body_bad_next;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    section_t         section_reg, section_next;
    logic             done_reg;
    logic             ok_reg, ok_next;
    err_t             err_reg, err_next;
    logic [7:0]       out_name_reg;
    logic [15:0]      out_body_reg;

    logic             adv;
    logic [POS_W-1:0] name_end;
    logic [POS_W-1:0] body_end;
    logic [POS_W:0]   total;
    logic [POS_W:0]   expected;
    text_step_t       ts;

    assign adv          = in_valid_reg && (!out_valid_reg || verdict.ready);
    assign record.ready = !in_valid_reg || adv;
    assign cfg.ready    = 1'b1;

    assign name_end = POS_W'(4) + POS_W'(name_len_reg);
    assign body_end = name_end + POS_W'(body_len_reg);

    always_comb
    begin
        pos_next       = pos_reg;
        name_len_next  = name_len_reg;
        body_len_next  = body_len_reg;
        first_err_next = first_err_reg;
        pend_next      = pend_reg;
        cls_next       = cls_reg;
        name_bad_next  = name_bad_reg;
        body_bad_next  = body_bad_reg;
        section_next   = SEC_BEYOND;
        ok_next        = 1'b0;
        err_next       = ERR_NONE;
        ts             = text_step(pend_reg, cls_reg, in_byte_reg,
                                   pos_reg >= name_end);
        total          = {1'b0, pos_reg} + (POS_W+1)'(1);
        expected       = '0;

        if (pos_reg < POS_W'(4)) begin
            section_next = SEC_HEADER;
            if ((pos_reg == POS_W'(0)) && (in_byte_reg != VERSION_BYTE)) begin
                first_err_next = ERR_VERSION;
            end
            if (pos_reg == POS_W'(1)) begin
                name_len_next = in_byte_reg;
            end
            if (pos_reg == POS_W'(2)) begin
                body_len_next = {8'h00, in_byte_reg};
            end
            if (pos_reg == POS_W'(3)) begin
                body_len_next = {in_byte_reg, body_len_reg[7:0]};
            end
            pend_next = 2'd0;
            cls_next  = CLS_80_BF;
        end else if (pos_reg < name_end) begin
            section_next = SEC_NAME;
            pend_next    = ts.pend;
            cls_next     = ts.cls;
            if (ts.bad) begin
                name_bad_next = 1'b1;
            end
            if ((pos_reg + POS_W'(1) == name_end) && (ts.pend != 2'd0)) begin
                name_bad_next = 1'b1;
                pend_next     = 2'd0;
                cls_next      = CLS_80_BF;
            end
        end else if (pos_reg < body_end) begin
            section_next = SEC_BODY;
            pend_next    = ts.pend;
            cls_next     = ts.cls;
            if (ts.bad) begin
                body_bad_next = 1'b1;
            end
            if ((pos_reg + POS_W'(1) == body_end) && (ts.pend != 2'd0)) begin
                body_bad_next = 1'b1;
                pend_next     = 2'd0;
                cls_next      = CLS_80_BF;
            end
        end

        expected = (POS_W+1)'(4) + (POS_W+1)'(name_len_next) + (POS_W+1)'(body_len_next);

        if (in_last_reg) begin
            if (total < (POS_W+1)'(4)) begin
                err_next = ERR_SHORT;
            end else if (first_err_next != ERR_NONE) begin
                err_next = first_err_next;
            end else if ((name_len_next == 8'd0) || (name_len_next > name_limit_reg)) begin
                err_next = ERR_NAME_LEN;
            end else if ((body_len_next == 16'd0) || (body_len_next > body_limit_reg)) begin
                err_next = ERR_BODY_LEN;
            end else if (total != expected) begin
                err_next = ERR_MISMATCH;
            end else if ((name_buf_reg <= {1'b0, name_len_next})
                         || (body_buf_reg <= {1'b0, body_len_next})) begin
                err_next = ERR_CAPACITY;
            end else if (name_bad_next) begin
                err_next = ERR_NAME_TEXT;
            end else if (body_bad_next) begin
                err_next = ERR_BODY_TEXT;
            end
            ok_next = (err_next == ERR_NONE);
        end

        if (in_last_reg) begin
            pos_next       = '0;
        end else if (pos_reg != POS_MAX) begin
            pos_next       = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            name_limit_reg <= NAME_LIMIT_RESET;
            body_limit_reg <= BODY_LIMIT_RESET;
            name_buf_reg   <= NAME_BUF_RESET;
            body_buf_reg   <= BODY_BUF_RESET;
        end else if (cfg.valid) begin
            case (cfg_index_t'(cfg.reg_index))
                REG_NAME_LIMIT: name_limit_reg <= cfg.wr_data[7:0];
                REG_BODY_LIMIT: body_limit_reg <= cfg.wr_data[15:0];
                REG_NAME_BUF:   name_buf_reg   <= cfg.wr_data[8:0];
                REG_BODY_BUF:   body_buf_reg   <= cfg.wr_data[16:0];
                default:        name_limit_reg <= name_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            name_len_reg  <= '0;
            body_len_reg  <= '0;
            first_err_reg <= ERR_NONE;
            pend_reg      <= 2'd0;
            cls_reg       <= CLS_80_BF;
            name_bad_reg  <= 1'b0;
            body_bad_reg  <= 1'b0;
        end else begin
            if (record.ready) begin
                in_valid_reg <= record.valid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (verdict.ready) begin
                out_valid_reg <= 1'b0;
            end
            if (adv) begin
                if (in_last_reg) begin
                    pos_reg       <= '0;
                    name_len_reg  <= '0;
                    body_len_reg  <= '0;
                    first_err_reg <= ERR_NONE;
                    pend_reg      <= 2'd0;
                    cls_reg       <= CLS_80_BF;
                    name_bad_reg  <= 1'b0;
                    body_bad_reg  <= 1'b0;
                end else begin
                    pos_reg       <= pos_next;
                    name_len_reg  <= name_len_next;
                    body_len_reg  <= body_len_next;
                    first_err_reg <= first_err_next;
                    pend_reg      <= pend_next;
                    cls_reg       <= cls_next;
                    name_bad_reg  <= name_bad_next;
                    body_bad_reg  <= body_bad_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (record.ready && record.valid) begin
            in_byte_reg <= record.data_byte;
            in_last_reg <= record.last_byte;
        end
        if (adv) begin
            out_byte_reg <= in_byte_reg;
            section_reg  <= section_next;
            done_reg     <= in_last_reg;
            ok_reg       <= ok_next;
            err_reg      <= err_next;
            out_name_reg <= name_len_next;
            out_body_reg <= body_len_next;
        end
    end

    assign verdict.valid      = out_valid_reg;
    assign verdict.out_byte   = out_byte_reg;
    assign verdict.section    = section_reg;
    assign verdict.done_res   = done_reg;
    assign verdict.record_ok  = ok_reg;
    assign verdict.error_code = err_reg;
    assign verdict.name_bytes = out_name_reg;
    assign verdict.body_bytes = out_body_reg;

    `TRU8_ASSERT_SAME(a_verdict_only_on_last, clk, rst_n,
        out_valid_reg && !done_reg, (err_reg == ERR_NONE) && !ok_reg)
    `TRU8_ASSERT_SAME(a_ok_means_no_error, clk, rst_n,
        out_valid_reg && ok_reg, (err_reg == ERR_NONE) && done_reg)
    `TRU8_ASSERT_NEXT(a_record_clears, clk, rst_n,
        adv && in_last_reg, (pos_reg == '0) && !name_bad_reg && !body_bad_reg)
    `TRU8_ASSERT_SAME(a_no_stall_when_empty, clk, rst_n,
        in_valid_reg && !out_valid_reg, adv)

endmodule
